### rtl/ripemd160_hash_defines.svh
// Assertion macros for the RIPEMD-160 block.
`ifndef RIPEMD160_HASH_DEFINES_SVH
`define RIPEMD160_HASH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RMD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define RMD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define RMD_ASSERT(label, prop)
`define RMD_ASSERT_RST(label, prop)
`endif
`endif

### rtl/rmd_pkg.sv
// Types, constants and round functions for the RIPEMD-160 block.
package rmd_pkg;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_COMP, S_FOLD, S_EMIT
  } core_state_e;

  typedef logic [31:0] word_t;

  localparam word_t Iv0 = 32'h67452301;
  localparam word_t Iv1 = 32'hefcdab89;
  localparam word_t Iv2 = 32'h98badcfe;
  localparam word_t Iv3 = 32'h10325476;
  localparam word_t Iv4 = 32'hc3d2e1f0;

  localparam logic [3:0] MsgL [80] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
    7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
    1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
  localparam logic [3:0] MsgR [80] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
    6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
    8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
  localparam logic [3:0] RotL [80] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
    7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
    11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
  localparam logic [3:0] RotR [80] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
    9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
    15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
  localparam word_t KonL [5] = '{32'h0, 32'h5a827999, 32'h6ed9eba1,
                                 32'h8f1bbcdc, 32'ha953fd4e};
  localparam word_t KonR [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                 32'h7a6d76e9, 32'h0};

  function automatic word_t rol(word_t x, logic [3:0] s);
    return (x << s) | (x >> (6'd32 - {2'b0, s}));
  endfunction

  function automatic word_t bool_fn(logic [2:0] sel, word_t x, word_t y, word_t z);
    case (sel)
      3'd0:    return x ^ y ^ z;
      3'd1:    return (x & y) | (~x & z);
      3'd2:    return (x | ~y) ^ z;
      3'd3:    return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction
endpackage

### rtl/rmd_if.sv
// Valid/ready channel carrying a payload of the given type.
interface rmd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/rmd_front.sv
// Input stage: takes requests, drops empty ones, queues the rest.
module rmd_front (
  input  logic clk_i,
  input  logic rst_ni,
  rmd_if.sink   in_i,
  rmd_if.source q_o
);
  rmd_pkg::req_t mem_q [rmd_pkg::QDepth];
  logic [rmd_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [rmd_pkg::QPtrW:0] cnt_q;
  logic push, pop;

  assign in_i.ready = (cnt_q != (rmd_pkg::QPtrW+1)'(rmd_pkg::QDepth));
  assign push = in_i.valid && in_i.ready && (in_i.data.has_byte || in_i.data.end_of_message);
  assign q_o.valid = (cnt_q != '0);
  assign q_o.data = mem_q[rd_q];
  assign pop = q_o.valid && q_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{rmd_pkg::QPtrW{1'b0}}, push} - {{rmd_pkg::QPtrW{1'b0}}, pop};
    end
  end
endmodule

### rtl/rmd_core.sv
// Block buffer, padding sequencer and one-round-pair compression unit.
module rmd_core (
  input  logic clk_i,
  input  logic rst_ni,
  rmd_if.sink   q_i,
  rmd_if.source out_o
);
  `include "ripemd160_hash_defines.svh"
  typedef rmd_pkg::word_t word_t;

  rmd_pkg::core_state_e state_q, state_d;
  word_t blk_q [16];
  word_t cv_q [5];
  word_t al_q, bl_q, cl_q, dl_q, el_q, ar_q, br_q, cr_q, dr_q, er_q;
  logic [63:0] bits_q, len_q;
  logic [5:0] pos_q;
  logic [6:0] rnd_q;
  logic [2:0] lidx_q;
  logic fin_q;
  // 0x80 marker already placed
  logic mark_q;
  // padding remains unless the length bytes went in
  logic len_done_q;
  logic [2:0] emit_q;
  rmd_pkg::rsp_t out_q;
  logic out_vld_q;

  // byte fed into the buffer this cycle
  logic       put;
  logic [7:0] put_byte;
  logic       take;

  always_comb begin
    state_d = state_q;
    put = 1'b0;
    put_byte = 8'h00;
    take = 1'b0;
    case (state_q)
      rmd_pkg::S_IDLE: if (q_i.valid) begin
        take = 1'b1;
        put = q_i.data.has_byte;
        put_byte = q_i.data.data_byte;
        if (q_i.data.has_byte && pos_q == 6'd63) state_d = rmd_pkg::S_COMP;
        else if (q_i.data.end_of_message) state_d = rmd_pkg::S_PAD;
      end
      rmd_pkg::S_PAD: begin
        put = 1'b1;
        put_byte = mark_q ? 8'h00 : 8'h80;
        if (pos_q == 6'd63) state_d = rmd_pkg::S_COMP;
        else if (pos_q == 6'd55) state_d = rmd_pkg::S_LEN;
      end
      rmd_pkg::S_LEN: begin
        put = 1'b1;
        put_byte = len_q[8*lidx_q +: 8];
        if (pos_q == 6'd63) state_d = rmd_pkg::S_COMP;
      end
      rmd_pkg::S_COMP: if (rnd_q == 7'd79) state_d = rmd_pkg::S_FOLD;
      rmd_pkg::S_FOLD: begin
        if (fin_q && !len_done_q) state_d = rmd_pkg::S_PAD;
        else if (fin_q) state_d = rmd_pkg::S_EMIT;
        else state_d = rmd_pkg::S_IDLE;
      end
      rmd_pkg::S_EMIT: if (!out_vld_q || out_o.ready) begin
        if (emit_q == 3'd4) state_d = rmd_pkg::S_IDLE;
      end
      default: state_d = rmd_pkg::S_IDLE;
    endcase
  end

  assign q_i.ready = take;

  word_t fl, fr, tl, tr;
  logic [2:0] grp;
  always_comb begin
    grp = 3'(rnd_q >> 4);
    fl = rmd_pkg::bool_fn(grp, bl_q, cl_q, dl_q);
    fr = rmd_pkg::bool_fn(3'd4 - grp, br_q, cr_q, dr_q);
    tl = rmd_pkg::rol(al_q + fl + blk_q[rmd_pkg::MsgL[rnd_q]] + rmd_pkg::KonL[grp],
                      rmd_pkg::RotL[rnd_q]) + el_q;
    tr = rmd_pkg::rol(ar_q + fr + blk_q[rmd_pkg::MsgR[rnd_q]] + rmd_pkg::KonR[grp],
                      rmd_pkg::RotR[rnd_q]) + er_q;
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      if (pos_q[1:0] == 2'd0) blk_q[pos_q[5:2]] <= {24'h0, put_byte};
      else blk_q[pos_q[5:2]][8*pos_q[1:0] +: 8] <= put_byte;
    end
    if (state_q == rmd_pkg::S_COMP) begin
      al_q <= el_q; el_q <= dl_q; dl_q <= rmd_pkg::rol(cl_q, 4'd10); cl_q <= bl_q; bl_q <= tl;
      ar_q <= er_q; er_q <= dr_q; dr_q <= rmd_pkg::rol(cr_q, 4'd10); cr_q <= br_q; br_q <= tr;
    end else begin
      {al_q, bl_q, cl_q, dl_q, el_q} <= {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4]};
      {ar_q, br_q, cr_q, dr_q, er_q} <= {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmd_pkg::S_IDLE;
      cv_q <= '{rmd_pkg::Iv0, rmd_pkg::Iv1, rmd_pkg::Iv2, rmd_pkg::Iv3, rmd_pkg::Iv4};
      bits_q <= '0;
      len_q <= '0;
      pos_q <= '0;
      rnd_q <= '0;
      lidx_q <= '0;
      fin_q <= 1'b0;
      mark_q <= 1'b0;
      len_done_q <= 1'b0;
      emit_q <= '0;
      out_vld_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      if (put) pos_q <= pos_q + 6'd1;
      if (take && q_i.data.has_byte) bits_q <= bits_q + 64'd8;
      if (take && q_i.data.end_of_message) begin
        fin_q <= 1'b1;
        len_q <= bits_q + (q_i.data.has_byte ? 64'd8 : 64'd0);
      end
      if (state_q == rmd_pkg::S_PAD) mark_q <= 1'b1;
      if (state_q == rmd_pkg::S_LEN) begin
        lidx_q <= lidx_q + 3'd1;
        if (lidx_q == 3'd7) len_done_q <= 1'b1;
      end
      if (state_q == rmd_pkg::S_COMP) rnd_q <= (rnd_q == 7'd79) ? 7'd0 : rnd_q + 7'd1;
      if (state_q == rmd_pkg::S_FOLD) begin
        cv_q[0] <= cv_q[1] + cl_q + dr_q;
        cv_q[1] <= cv_q[2] + dl_q + er_q;
        cv_q[2] <= cv_q[3] + el_q + ar_q;
        cv_q[3] <= cv_q[4] + al_q + br_q;
        cv_q[4] <= cv_q[0] + bl_q + cr_q;
      end
      if (state_q == rmd_pkg::S_EMIT && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
        out_q.digest_word <= cv_q[emit_q];
        out_q.word_index <= emit_q;
        out_q.last_word <= (emit_q == 3'd4);
        if (emit_q == 3'd4) begin
          emit_q <= '0;
          cv_q <= '{rmd_pkg::Iv0, rmd_pkg::Iv1, rmd_pkg::Iv2, rmd_pkg::Iv3, rmd_pkg::Iv4};
          bits_q <= '0;
          pos_q <= '0;
          lidx_q <= '0;
          fin_q <= 1'b0;
          mark_q <= 1'b0;
          len_done_q <= 1'b0;
        end else emit_q <= emit_q + 3'd1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data = out_q;

  `RMD_ASSERT(a_rnd_comp, (rnd_q != 7'd0) |-> (state_q == rmd_pkg::S_COMP))
  `RMD_ASSERT(a_no_take_busy, take |-> (state_q == rmd_pkg::S_IDLE))
  `RMD_ASSERT(a_emit_idx, out_vld_q |-> (out_q.word_index <= 3'd4))
  `RMD_ASSERT(a_last, out_vld_q |-> (out_q.last_word == (out_q.word_index == 3'd4)))
endmodule

### rtl/ripemd160_hash.sv
// RIPEMD-160 hash, top level.
// One message byte per request; a request with end_of_message set pads the
// message, finishes it and returns the digest as five 32-bit words, index 0
// first, each word's bytes little-endian. Requests pass a four-entry queue,
// which registers them, and the core then takes one byte a cycle into its
// block buffer while idle; each full 64-byte block occupies the single
// compression unit for 80 round pairs plus the chaining fold, during which no
// byte is taken. A finished message adds padding and length bytes up to the
// end of the block and a second padded block when fewer than nine bytes
// remain; each padded block is compressed the same way before the five
// digest words are sent.
module ripemd160_hash (
  input  logic clk_i,
  input  logic rst_ni,
  rmd_if.sink   in_i,
  rmd_if.source out_o
);
  rmd_if #(.T(rmd_pkg::req_t)) q_ch ();

  rmd_front u_front (.clk_i, .rst_ni, .in_i, .q_o(q_ch.source));
  rmd_core  u_core  (.clk_i, .rst_ni, .q_i(q_ch.sink), .out_o);
endmodule

### tb/tb_top.sv
// Testbench for the RIPEMD-160 hash block: random and directed byte streams, scoreboard check.
module tb_top;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmd_if #(.T(rmd_pkg::req_t)) req_ch ();
  rmd_if #(.T(rmd_pkg::rsp_t)) rsp_ch ();

  ripemd160_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (rsp_ch.source)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // golden hash state
  rmd_pkg::word_t chain_q [5];
  rmd_pkg::word_t blk_q [16];
  logic [5:0]     fill_q;
  logic [63:0]    nbits_q;

  rmd_pkg::req_t req_pend_q [$];
  rmd_pkg::rsp_t digest_exp_q [$];

  int unsigned mismatch_cnt = 0;
  int unsigned words_seen = 0;
  int unsigned msgs_sent = 0;
  int unsigned reqs_sent = 0;
  int unsigned src_idle_pct = 22;
  int unsigned snk_idle_pct = 79;
  logic        hold_on = 1'b0;

  function automatic rmd_pkg::word_t rotl(rmd_pkg::word_t x, int unsigned s);
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic rmd_pkg::word_t mix_fn(int unsigned sel, rmd_pkg::word_t x,
                                            rmd_pkg::word_t y, rmd_pkg::word_t z);
    case (sel)
      0:       return x ^ y ^ z;
      1:       return (x & y) | (~x & z);
      2:       return (x | ~y) ^ z;
      3:       return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  task automatic compress_block();
    rmd_pkg::word_t al, bl, cl, dl, el, ar, br, cr, dr, er, t;
    int unsigned r;
    al = chain_q[0]; bl = chain_q[1]; cl = chain_q[2]; dl = chain_q[3]; el = chain_q[4];
    ar = al; br = bl; cr = cl; dr = dl; er = el;
    for (int j = 0; j < 80; j++) begin
      r = j / 16;
      t = rotl(al + mix_fn(r, bl, cl, dl) + blk_q[rmd_pkg::MsgL[j]] + rmd_pkg::KonL[r],
               rmd_pkg::RotL[j]) + el;
      al = el; el = dl; dl = rotl(cl, 10); cl = bl; bl = t;
      t = rotl(ar + mix_fn(4 - r, br, cr, dr) + blk_q[rmd_pkg::MsgR[j]] + rmd_pkg::KonR[r],
               rmd_pkg::RotR[j]) + er;
      ar = er; er = dr; dr = rotl(cr, 10); cr = br; br = t;
    end
    t = chain_q[1] + cl + dr;
    chain_q[1] = chain_q[2] + dl + er;
    chain_q[2] = chain_q[3] + el + ar;
    chain_q[3] = chain_q[4] + al + br;
    chain_q[4] = chain_q[0] + bl + cr;
    chain_q[0] = t;
  endtask

  task automatic absorb_byte(logic [7:0] b);
    if (fill_q[1:0] == 2'd0) blk_q[fill_q[5:2]] = {24'd0, b};
    else blk_q[fill_q[5:2]] |= rmd_pkg::word_t'(b) << (8 * fill_q[1:0]);
    fill_q = fill_q + 6'd1;
    if (fill_q == 6'd0) compress_block();
  endtask

  task automatic hash_init();
    chain_q = '{rmd_pkg::Iv0, rmd_pkg::Iv1, rmd_pkg::Iv2, rmd_pkg::Iv3, rmd_pkg::Iv4};
    nbits_q = '0;
    fill_q = '0;
  endtask

  // predict the digest words produced by one accepted request
  task automatic predict_digest(rmd_pkg::req_t r);
    logic [63:0] len;
    rmd_pkg::rsp_t w;
    if (r.has_byte) begin
      absorb_byte(r.data_byte);
      nbits_q += 64'd8;
    end
    if (!r.end_of_message) return;
    len = nbits_q;
    absorb_byte(8'h80);
    while (fill_q != 6'd56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(len[8*i +: 8]);
    for (int i = 0; i < 5; i++) begin
      w.digest_word = chain_q[i];
      w.word_index = 3'(i);
      w.last_word = (i == 4);
      digest_exp_q.push_back(w);
    end
    hash_init();
  endtask

  function automatic rmd_pkg::req_t mk_req(logic [7:0] b, logic hb, logic eom);
    rmd_pkg::req_t r;
    r.data_byte = b; r.has_byte = hb; r.end_of_message = eom;
    return r;
  endfunction

  task automatic queue_message(int unsigned len);
    for (int i = 0; i < len; i++)
      req_pend_q.push_back(mk_req(8'($urandom), 1'b1, i == len - 1));
    if (len == 0) req_pend_q.push_back(mk_req(8'($urandom), 1'b0, 1'b1));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_digest(req_ch.data);
        reqs_sent++;
        if (req_ch.data.end_of_message) msgs_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_pend_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= req_pend_q.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering requests
  initial begin
    wait (msgs_sent >= 5);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_seen++;
        if (digest_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected digest word %h", rsp_ch.data);
        end else if (rsp_ch.data !== digest_exp_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("digest mismatch: exp word %h idx %0d last %0d, got %h idx %0d last %0d",
                     digest_exp_q[0].digest_word, digest_exp_q[0].word_index,
                     digest_exp_q[0].last_word, rsp_ch.data.digest_word,
                     rsp_ch.data.word_index, rsp_ch.data.last_word);
          void'(digest_exp_q.pop_front());
        end else begin
          void'(digest_exp_q.pop_front());
        end
      end
      if (hold_on) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    hash_init();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle item, empty message, single byte 0x00, two-byte message with an idle item inside, short message
    req_pend_q.push_back(mk_req(8'h00, 1'b0, 1'b0));
    req_pend_q.push_back(mk_req(8'hff, 1'b0, 1'b1));
    req_pend_q.push_back(mk_req(8'h00, 1'b1, 1'b1));
    req_pend_q.push_back(mk_req(8'hff, 1'b1, 1'b0));
    req_pend_q.push_back(mk_req(8'h5a, 1'b0, 1'b0));
    req_pend_q.push_back(mk_req(8'ha5, 1'b1, 1'b0));
    req_pend_q.push_back(mk_req(8'h3c, 1'b0, 1'b1));
    for (int i = 0; i < 3; i++) req_pend_q.push_back(mk_req(8'h61 + 8'(i), 1'b1, i == 2));
    while (req_pend_q.size() > 0 || digest_exp_q.size() > 0 || req_ch.valid)
      @(posedge clk_i);

    // one long message whose padding spills into a second block, then short random ones
    queue_message($urandom_range(56, 64));
    while (reqs_sent < 100) begin
      if (reqs_sent >= 45 && reqs_sent < 80) begin
        src_idle_pct = 79; snk_idle_pct = 22;
      end else if (reqs_sent >= 80) begin
        src_idle_pct = 0; snk_idle_pct = 0;
      end
      if (req_pend_q.size() == 0) begin
        case ($urandom_range(9))
          0:       queue_message(0);
          1:       req_pend_q.push_back(mk_req(8'($urandom), 1'b0, 1'b0));
          default: queue_message($urandom_range(1, 12));
        endcase
      end
      @(posedge clk_i);
    end
    while (req_pend_q.size() > 0 || req_ch.valid) @(posedge clk_i);
    // close any open message so no request is left pending in the block
    req_pend_q.push_back(mk_req(8'h00, 1'b0, 1'b1));
    while (req_pend_q.size() > 0 || req_ch.valid || digest_exp_q.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d requests in %0d messages, %0d digest words checked",
             reqs_sent, msgs_sent, words_seen);
    if (mismatch_cnt == 0 && digest_exp_q.size() == 0)
      $display("ripemd160_hash verification clean");
    else
      $display("ripemd160_hash verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("ripemd160_hash verification failed");
    $finish;
  end
endmodule
